// ===== sv/p5td_pkg.sv =====
// p5td_pkg: shared types, code values and character tables for the
// packed five-bit text decoder; depends on nothing
package p5td_pkg;

   localparam int WORD_W  = 16;
   localparam int CODE_W  = 5;
   localparam int CHAR_W  = 8;
   localparam int NUM_POS = 3;
   localparam int CNT_W   = 2;

   localparam logic [CODE_W-1:0] CODE_MASK   = 5'h1f;
   localparam logic [CODE_W-1:0] SHIFT_PUNCT = 5'd0;
   localparam logic [CODE_W-1:0] SHIFT_UPPER = 5'd1;
   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;

   // which alphabet the next code maps through
   typedef enum logic [1:0] {
      ALPHA_NONE  = 2'd0,
      ALPHA_PUNCT = 2'd1,
      ALPHA_UPPER = 2'd2
   } alphabet_type;

   // result of unpacking one word
   typedef struct packed {
      logic [NUM_POS-1:0][CHAR_W-1:0] chars;
      logic [NUM_POS-1:0]             eos;
      logic [CNT_W-1:0]               count;
      alphabet_type                   next_alpha;
   } decode_type;

   // lowercase alphabet, codes 0 and 1 are never looked up here
   localparam logic [CHAR_W-1:0] LOWER_TAB [32] = '{
      8'h00, 8'h00, 8'h20, 8'h88, 8'h8e, 8'h8f, 8'h61, 8'h62,
      8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
      8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
      8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
   };

   // punctuation and digit alphabet
   localparam logic [CHAR_W-1:0] PUNCT_TAB [32] = '{
      8'h00, 8'h21, 8'h22, 8'h89, 8'h9d, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h99, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h8d,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'ha1, 8'h3f
   };

   // uppercase and accented alphabet
   localparam logic [CHAR_W-1:0] UPPER_TAB [32] = '{
      8'h90, 8'h91, 8'h94, 8'h95, 8'h9e, 8'h9f, 8'h41, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
      8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
      8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a
   };

endpackage

// ===== sv/p5td_req_if.sv =====
// p5td_req_if: input channel carrying one packed word per transaction
// depends on p5td_pkg
interface p5td_req_if import p5td_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] packed_word;
   logic              start_of_record;

   modport source (output valid, output packed_word, output start_of_record, input ready);
   modport sink   (input valid, input packed_word, input start_of_record, output ready);
endinterface

// ===== sv/p5td_rsp_if.sv =====
// p5td_rsp_if: result channel carrying one character per transaction
// depends on p5td_pkg
interface p5td_rsp_if import p5td_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_string;
   logic              last_of_word;

   modport source (output valid, output char_code, output end_of_string,
                   output last_of_word, input ready);
   modport sink   (input valid, input char_code, input end_of_string,
                   input last_of_word, output ready);
endinterface

// ===== sv/p5td_unpack.sv =====
// p5td_unpack: splits one packed word into up to three characters and
// tracks the shift carried between words; depends on p5td_pkg
module p5td_unpack import p5td_pkg::*; (
   input  logic [WORD_W-1:0] packed_word,
   input  logic              start_of_record,
   input  alphabet_type      cur_alpha,
   output decode_type        decode
);

   always_comb begin
      alphabet_type      alpha;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      logic              emit;
      logic [CNT_W-1:0]  cnt;

      // start of record drops any pending shift
      alpha  = start_of_record ? ALPHA_NONE : cur_alpha;
      decode = '0;
      cnt    = '0;
      code   = '0;
      ch     = '0;
      emit   = 1'b0;

      // walk the three codes, most significant first
      for (int pos = 0; pos < NUM_POS; pos++) begin
         code = packed_word[WORD_W-1-CODE_W*pos -: CODE_W] & CODE_MASK;
         emit = 1'b0;
         ch   = CHAR_NUL;
         case (alpha)
            ALPHA_PUNCT: begin
               ch    = PUNCT_TAB[code];
               emit  = 1'b1;
               alpha = ALPHA_NONE;
            end
            ALPHA_UPPER: begin
               ch    = UPPER_TAB[code];
               emit  = 1'b1;
               alpha = ALPHA_NONE;
            end
            default: begin
               if (code == SHIFT_PUNCT) begin
                  alpha = ALPHA_PUNCT;
               end else if (code == SHIFT_UPPER) begin
                  alpha = ALPHA_UPPER;
               end else begin
                  ch    = LOWER_TAB[code];
                  emit  = 1'b1;
                  alpha = ALPHA_NONE;
               end
            end
         endcase
         // pack emitted characters from slot zero up
         if (emit) begin
            decode.chars[cnt] = ch;
            decode.eos[cnt]   = (ch == CHAR_NUL);
            cnt               = cnt + 2'd1;
         end
      end

      decode.count      = cnt;
      decode.next_alpha = alpha;
   end

endmodule

// ===== sv/packed_5bit_text_decoder_top.sv =====
// packed_5bit_text_decoder_top: unpacks five-bit coded words into a
// character stream; depends on p5td_pkg, p5td_req_if, p5td_rsp_if, p5td_unpack
//
//   channel  direction  per transaction
//   req      in         packed_word[15:0], start_of_record
//   rsp      out        char_code[7:0], end_of_string, last_of_word
//
// a word is unpacked in the cycle it is accepted and its one to three
// characters go out from a register buffer, one per cycle while rsp is ready
// the next word is taken in the cycle the last character of the previous
// one leaves
// reset clears the busy flag and the pending shift; a stalled rsp holds the
// buffer and req ready stays low until its last character is taken
module packed_5bit_text_decoder_top import p5td_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   p5td_req_if.sink   req_chan,
   p5td_rsp_if.source rsp_chan
);

   decode_type                     decode;
   alphabet_type                   alpha_ff;
   logic                           busy_ff;
   logic [NUM_POS-1:0][CHAR_W-1:0] chars_ff;
   logic [NUM_POS-1:0]             eos_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               idx_ff;
   logic [CNT_W-1:0]               idx_in;
   logic                           last_char;
   logic                           rsp_take;
   logic                           last_take;
   logic                           req_take;

   // word unpacking
   p5td_unpack u_unpack (
      .packed_word     (req_chan.packed_word),
      .start_of_record (req_chan.start_of_record),
      .cur_alpha       (alpha_ff),
      .decode          (decode)
   );

   // handshake
   assign last_char      = (idx_ff == count_ff - 2'd1);
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;
   assign last_take      = rsp_take && last_char;
   assign req_chan.ready = !busy_ff || last_take;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign idx_in         = idx_ff + 2'd1;

   // result outputs straight from the buffer
   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.char_code     = chars_ff[idx_ff];
   assign rsp_chan.end_of_string = eos_ff[idx_ff];
   assign rsp_chan.last_of_word  = last_char;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         alpha_ff <= ALPHA_NONE;
      end else if (req_take) begin
         busy_ff  <= 1'b1;
         alpha_ff <= decode.next_alpha;
      end else if (last_take) begin
         busy_ff  <= 1'b0;
      end
   end

   // character buffer
   always_ff @(posedge clock) begin
      if (req_take) begin
         chars_ff <= decode.chars;
         eos_ff   <= decode.eos;
         count_ff <= decode.count;
         idx_ff   <= '0;
      end else if (rsp_take) begin
         idx_ff   <= idx_in;
      end
   end

endmodule
